@@ rtl/pidc_pkg.sv @@
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared types and constants of the two-mode PID controller: sequencer
// states, multiply operations, controller/datapath command and status.
// ----------------------------------------------------------------------------
package pidc_pkg;

	// slice of the second multiplier operand handled per cycle
	localparam int MUL_DIGIT = 16;

	// configuration register indexes
	localparam logic [2:0] REG_KP     = 3'd0;
	localparam logic [2:0] REG_KI     = 3'd1;
	localparam logic [2:0] REG_KD     = 3'd2;
	localparam logic [2:0] REG_DT     = 3'd3;
	localparam logic [2:0] REG_RDT    = 3'd4;
	localparam logic [2:0] REG_UPPER  = 3'd5;
	localparam logic [2:0] REG_LOWER  = 3'd6;
	localparam logic [2:0] REG_THRESH = 3'd7;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIFF,
		ST_MSEL,
		ST_MUL,
		ST_WB,
		ST_SUM,
		ST_CLAMP,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		OP_P,     // Kp * error
		OP_INT,   // error * dt, into the integral
		OP_I,     // Ki * integral
		OP_RATE,  // error difference * 1/dt
		OP_D      // Kd * rate or Kd * velocity difference
	} op_t;

	typedef struct packed {
		logic load;
		logic prep;
		logic diff;
		logic mul_load;
		logic mul_step;
		logic wb;
		logic sum;
		logic clamp;
		logic out_load;
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic kind;
	} status_t;

endpackage

@@ rtl/pidc_mul.sv @@
// ----------------------------------------------------------------------------
// pidc_mul
// Shared sequential multiplier: signed a times signed b, one 16-bit slice
// of b per cycle while step is high, most significant slice first. Exact full product.
// ----------------------------------------------------------------------------
module pidc_mul import pidc_pkg::*; #(
	parameter int DW  = 32,
	parameter int BW  = 48,
	parameter int NCH = 3
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              load,
	input  logic                              step,
	input  logic signed [DW-1:0]              a,
	input  logic signed [BW-1:0]              b,
	output logic signed [DW+NCH*MUL_DIGIT-1:0] prod
);

	localparam int NB  = NCH * MUL_DIGIT;
	localparam int AW  = DW + NB;
	localparam int PPW = DW + MUL_DIGIT + 1;

	logic signed [DW-1:0]    a_q;
	logic        [NB-1:0]    b_q;
	logic signed [AW-1:0]    acc_q;
	logic                    first_q;
	logic [MUL_DIGIT-1:0]    chunk;
	logic                    ext;
	logic signed [PPW-1:0]   pp;

	assign chunk = b_q[NB-1 -: MUL_DIGIT];
	assign ext   = first_q & chunk[MUL_DIGIT-1];
	assign pp    = a_q * $signed({ext, chunk});
	assign prod  = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b0;
		end else if (load) begin
			first_q <= 1'b1;
		end else if (step) begin
			first_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			a_q   <= a;
			b_q   <= NB'(b);
			acc_q <= '0;
		end else if (step) begin
			acc_q <= (acc_q << MUL_DIGIT) + AW'(pp);
			b_q   <= b_q << MUL_DIGIT;
		end
	end

endmodule

@@ rtl/pidc_dpath.sv @@
// ----------------------------------------------------------------------------
// pidc_dpath
// Datapath: configuration registers, loop state, error and difference
// terms, operand selection for the shared multiplier, saturation, sum
// and output clamp, output register.
// ----------------------------------------------------------------------------
module pidc_dpath import pidc_pkg::*; #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16,
	parameter int ACC_WIDTH  = 48,
	parameter int IN_TW      = 128,
	parameter int OUT_TW     = 32,
	parameter int BW         = 48,
	parameter int NCH        = 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output status_t               status,
	input  logic                  cfg_wen,
	input  logic [2:0]            cfg_index,
	input  logic [DATA_WIDTH-1:0] cfg_data,
	input  logic [IN_TW-1:0]      in_data,
	input  logic                  in_kind,
	output logic [OUT_TW-1:0]     out_data
);

	localparam int DW  = DATA_WIDTH;
	localparam int DW1 = DW + 1;
	localparam int AW  = DW + NCH * MUL_DIGIT;
	localparam int SW  = AW + 2;

	localparam logic signed [DW-1:0] DW_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] DW_MIN = {1'b1, {(DW-1){1'b0}}};
	localparam logic signed [SW-1:0] ACC_MAX_X =
		{{(SW-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
	localparam logic signed [SW-1:0] ACC_MIN_X =
		{{(SW-ACC_WIDTH+1){1'b1}}, {(ACC_WIDTH-1){1'b0}}};
	localparam logic [DW-2:0] ONE_Q  = (DW-1)'(1) << FRAC_BITS;
	localparam logic [DW-2:0] HALF_Q = (DW-1)'(1) << (FRAC_BITS-1);

	function automatic logic signed [DW-1:0] sat_dw(input logic signed [DW:0] v);
		if (v[DW] != v[DW-1]) return v[DW] ? DW_MIN : DW_MAX;
		return v[DW-1:0];
	endfunction

	function automatic logic signed [ACC_WIDTH-1:0] sat_acc(input logic signed [SW-1:0] v);
		if (v > ACC_MAX_X) return ACC_MAX_X[ACC_WIDTH-1:0];
		if (v < ACC_MIN_X) return ACC_MIN_X[ACC_WIDTH-1:0];
		return v[ACC_WIDTH-1:0];
	endfunction

	// configuration
	logic signed [DW-1:0] kp_q, ki_q, kd_q, upper_q, lower_q;
	logic        [DW-2:0] dt_q, rdt_q, thr_q;

	// request and loop state
	logic                        kind_q;
	logic signed [DW-1:0]        sp_q, meas_q, spv_q, mv_q;
	logic signed [DW-1:0]        err_q, vdiff_q, diff_q;
	logic                        jump_q;
	logic signed [DW-1:0]        last_err_q, last_sp_q;
	logic signed [ACC_WIDTH-1:0] isum_q, p_q, i_q, rate_q, d_q, sum_q;
	logic        [DW-1:0]        drive_q, out_q;

	logic signed [DW:0]    err_wide, vdiff_wide, jump_wide, diff_wide;
	logic        [DW:0]    jump_mag;
	logic signed [DW-1:0]  mul_a;
	logic signed [BW-1:0]  mul_b;
	logic signed [AW-1:0]  prod, shifted;
	logic signed [SW-1:0]  isum_wide, total_wide, sum_x, up_x, lo_x, clamp_x;

	pidc_mul #(
		.DW  (DW),
		.BW  (BW),
		.NCH (NCH)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (cmd.mul_load),
		.step   (cmd.mul_step),
		.a      (mul_a),
		.b      (mul_b),
		.prod   (prod)
	);

	assign err_wide   = DW1'(sp_q) - DW1'(meas_q);
	assign vdiff_wide = DW1'(spv_q) - DW1'(mv_q);
	assign jump_wide  = DW1'(sp_q) - DW1'(last_sp_q);
	assign diff_wide  = DW1'(err_q) - DW1'(last_err_q);
	assign jump_mag   = jump_wide[DW] ? DW1'(-jump_wide) : DW1'(jump_wide);

	assign shifted    = prod >>> FRAC_BITS;
	assign isum_wide  = SW'(isum_q) + SW'(shifted);
	assign total_wide = SW'(p_q) + SW'(i_q) + SW'(d_q);

	assign sum_x   = SW'(sum_q);
	assign up_x    = SW'(upper_q);
	assign lo_x    = SW'(lower_q);
	assign clamp_x = (sum_x > up_x) ? up_x : ((sum_x < lo_x) ? lo_x : sum_x);

	always_comb begin
		case (cmd.op)
			OP_P: begin
				mul_a = kp_q;
				mul_b = BW'(err_q);
			end
			OP_INT: begin
				mul_a = err_q;
				mul_b = BW'(dt_q);
			end
			OP_I: begin
				mul_a = ki_q;
				mul_b = BW'(isum_q);
			end
			OP_RATE: begin
				mul_a = diff_q;
				mul_b = BW'(rdt_q);
			end
			OP_D: begin
				mul_a = kd_q;
				mul_b = kind_q ? BW'(vdiff_q) : BW'(rate_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q    <= '0;
			ki_q    <= '0;
			kd_q    <= '0;
			dt_q    <= ONE_Q;
			rdt_q   <= ONE_Q;
			upper_q <= DW_MAX;
			lower_q <= DW_MIN;
			thr_q   <= HALF_Q;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_KP:     kp_q    <= cfg_data;
				REG_KI:     ki_q    <= cfg_data;
				REG_KD:     kd_q    <= cfg_data;
				REG_DT:     dt_q    <= cfg_data[DW-2:0];
				REG_RDT:    rdt_q   <= cfg_data[DW-2:0];
				REG_UPPER:  upper_q <= cfg_data;
				REG_LOWER:  lower_q <= cfg_data;
				REG_THRESH: thr_q   <= cfg_data[DW-2:0];
				default: ;
			endcase
		end
	end

	// loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_err_q <= '0;
			last_sp_q  <= '0;
			isum_q     <= '0;
		end else begin
			if (cmd.diff && !kind_q && jump_q) begin
				isum_q <= '0;
			end else if (cmd.wb && cmd.op == OP_INT) begin
				isum_q <= sat_acc(isum_wide);
			end
			if (cmd.clamp) begin
				last_err_q <= err_q;
				if (!kind_q) begin
					last_sp_q <= sp_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= in_kind;
			sp_q   <= in_data[DW-1:0];
			meas_q <= in_data[2*DW-1:DW];
			spv_q  <= in_data[3*DW-1:2*DW];
			mv_q   <= in_data[4*DW-1:3*DW];
		end
		if (cmd.prep) begin
			err_q   <= sat_dw(err_wide);
			vdiff_q <= sat_dw(vdiff_wide);
			jump_q  <= jump_mag > DW1'(thr_q);
		end
		if (cmd.diff) begin
			diff_q <= sat_dw(diff_wide);
		end
		if (cmd.wb) begin
			case (cmd.op)
				OP_P:    p_q    <= sat_acc(SW'(shifted));
				OP_I:    i_q    <= sat_acc(SW'(shifted));
				OP_RATE: rate_q <= sat_acc(SW'(shifted));
				OP_D:    d_q    <= sat_acc(SW'(shifted));
				default: ;
			endcase
		end
		if (cmd.sum) begin
			sum_q <= sat_acc(total_wide);
		end
		if (cmd.clamp) begin
			drive_q <= clamp_x[DW-1:0];
		end
		if (cmd.out_load) begin
			out_q <= drive_q;
		end
	end

	assign status.kind = kind_q;
	assign out_data    = OUT_TW'(out_q);

endmodule

@@ rtl/pidc_ctrl.sv @@
// ----------------------------------------------------------------------------
// pidc_ctrl
// Sequencer: accepts a request, steps the datapath through error terms and
// the chain of multiplies, and hands the result to the output register.
// ----------------------------------------------------------------------------
module pidc_ctrl import pidc_pkg::*; #(
	parameter int NCH = 3
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  status_t status,
	output cmd_t    cmd
);

	localparam int CNT_W = (NCH > 1) ? $clog2(NCH) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NCH - 1);

	state_t           state_q, state_next;
	op_t              op_q, op_next;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		unique case (op_q)
			OP_P:    op_next = OP_INT;
			OP_INT:  op_next = OP_I;
			OP_I:    op_next = status.kind ? OP_D : OP_RATE;
			OP_RATE: op_next = OP_D;
			OP_D:    op_next = OP_P;
			default: op_next = OP_P;
		endcase
	end

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		cmd.op     = op_q;
		in_ready   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load   = 1'b1;
					state_next = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep   = 1'b1;
				state_next = ST_DIFF;
			end
			ST_DIFF: begin
				cmd.diff   = 1'b1;
				state_next = ST_MSEL;
			end
			ST_MSEL: begin
				cmd.mul_load = 1'b1;
				state_next   = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul_step = 1'b1;
				if (cnt_q == CNT_LAST) begin
					state_next = ST_WB;
				end
			end
			ST_WB: begin
				cmd.wb     = 1'b1;
				state_next = (op_q == OP_D) ? ST_SUM : ST_MSEL;
			end
			ST_SUM: begin
				cmd.sum    = 1'b1;
				state_next = ST_CLAMP;
			end
			ST_CLAMP: begin
				cmd.clamp  = 1'b1;
				state_next = ST_OUT;
			end
			ST_OUT: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_next   = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_P;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.load) begin
				op_q <= OP_P;
			end else if (cmd.wb) begin
				op_q <= op_next;
			end
			if (cmd.mul_load) begin
				cnt_q <= '0;
			end else if (cmd.mul_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ rtl/pid_controller_two_mode_unit.sv @@
// ----------------------------------------------------------------------------
// pid_controller_two_mode_unit
// Two-mode fixed-point PID controller with saturating integral and output
// clamp, stream request/result ports and a plain register write port.
// ----------------------------------------------------------------------------
// Each request is one control tick and yields exactly one drive result.
// A request runs 5 multiplies in error mode and 4 in velocity mode, one
// after another on the single shared multiplier, which takes one 16-bit
// slice of its second operand per cycle; NCH is the number of 16-bit
// slices of the wider of ACC_WIDTH and DATA_WIDTH. No new request is taken
// until the result is in the output register. A finished result sits in the
// output register, so the next request is accepted while it waits; the
// sequencer only stalls when a second result is ready before the first has
// been taken. The user must write registers with cfg_wen only while idle;
// the block itself does not enforce it.
module pid_controller_two_mode_unit import pidc_pkg::*; #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16,
	parameter int ACC_WIDTH  = 48,
	localparam int IN_TW  = ((4 * DATA_WIDTH + 7) / 8) * 8,
	localparam int OUT_TW = ((DATA_WIDTH + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// setpoint, measured, setpoint_velocity, measured_velocity
	input  logic [IN_TW-1:0]      s_axis_tdata,
	// kind
	input  logic [0:0]            s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// drive
	output logic [OUT_TW-1:0]     m_axis_tdata,
	input  logic                  cfg_wen,
	input  logic [2:0]            cfg_index,
	input  logic [DATA_WIDTH-1:0] cfg_data
);

	localparam int BW  = (ACC_WIDTH > DATA_WIDTH) ? ACC_WIDTH : DATA_WIDTH;
	localparam int NCH = (BW + MUL_DIGIT - 1) / MUL_DIGIT;

	cmd_t    cmd;
	status_t status;

	pidc_ctrl #(
		.NCH (NCH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.status    (status),
		.cmd       (cmd)
	);

	pidc_dpath #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS),
		.ACC_WIDTH  (ACC_WIDTH),
		.IN_TW      (IN_TW),
		.OUT_TW     (OUT_TW),
		.BW         (BW),
		.NCH        (NCH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_axis_tdata),
		.in_kind   (s_axis_tuser[0]),
		.out_data  (m_axis_tdata)
	);

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> cmd.prep && !s_axis_tready)
		else $error("accepted request did not start processing");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !m_axis_tvalid || m_axis_tready)
		else $error("output register loaded while a result is held");

	a_wb_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wb |-> $past(cmd.mul_step))
		else $error("product written back without a multiply step");

	a_busy_while_mul: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_step |-> !s_axis_tready)
		else $error("ready raised during a multiply");

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-mode PID controller. Control ticks go in
// on the request stream and every tick is predicted in Q16.16 from the
// bench's own copy of the gains, limits and controller state. Drive results
// are checked in order. Directed ticks cover field extremes, both modes,
// the setpoint jump test, clamping and saturation. Random phases follow,
// each under new register settings, with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_top import pidc_pkg::*; ();

	localparam int  DW             = 32;
	localparam int  FRAC           = 16;
	localparam int  AW             = 48;
	localparam int  WATCHDOG_LIMIT = 2000;
	localparam int  RAND_PHASES    = 10;
	localparam int  PHASE_TICKS    = 105;
	localparam int  TAIL_TICKS     = 125;
	localparam logic KIND_ERROR    = 1'b0;
	localparam logic KIND_VELOCITY = 1'b1;
	localparam logic [31:0] Q_MAX  = 32'h7FFF_FFFF;
	localparam logic [31:0] Q_MIN  = 32'h8000_0000;
	localparam logic [31:0] Q_ONE  = 32'h0001_0000;

	typedef logic signed [127:0] wide_t;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           s_axis_tvalid = 1'b0;
	logic           s_axis_tready;
	// setpoint, measured, setpoint_velocity, measured_velocity
	logic [127:0]   s_axis_tdata = '0;
	// kind
	logic [0:0]     s_axis_tuser = '0;
	logic           m_axis_tvalid;
	logic           m_axis_tready = 1'b0;
	// drive
	logic [31:0]    m_axis_tdata;
	logic           cfg_wen = 1'b0;
	logic [2:0]     cfg_index = REG_KP;
	logic [DW-1:0]  cfg_data = '0;

	pid_controller_two_mode_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// controller copy: settings and state
	wide_t kp_q = 0, ki_q = 0, kd_q = 0;
	wide_t dt_q = 65536, rdt_q = 65536, thresh_q = 32768;
	wide_t upper_q = 128'sd2147483647, lower_q = -128'sd2147483648;
	wide_t last_err_q = 0, integral_q = 0, last_sp_q = 0;

	logic [31:0] drive_expect[$];
	logic [31:0] drive_want;
	logic [31:0] recent_sp = '0;
	int          errors = 0;
	int          quiet = 0;
	int          stall_left = 0;
	bit          calm = 1'b0;

	function automatic wide_t clip(input wide_t v, input int w);
		wide_t top;
		top = (wide_t'(1) <<< (w - 1)) - 1;
		if (v > top) return top;
		if (v < -top - 1) return -top - 1;
		return v;
	endfunction

	// Q product, floor, held to 64 bits
	function automatic wide_t q_mul(input wide_t a, input wide_t b);
		return clip((a * b) >>> FRAC, 64);
	endfunction

	function automatic wide_t sx(input logic [31:0] v);
		return wide_t'($signed(v));
	endfunction

	function automatic void note_reg(input logic [2:0] idx, input logic [31:0] v);
		wide_t u;
		u = wide_t'({1'b0, v[30:0]});
		case (idx)
			REG_KP:     kp_q = sx(v);
			REG_KI:     ki_q = sx(v);
			REG_KD:     kd_q = sx(v);
			REG_DT:     dt_q = u;
			REG_RDT:    rdt_q = u;
			REG_UPPER:  upper_q = sx(v);
			REG_LOWER:  lower_q = sx(v);
			REG_THRESH: thresh_q = u;
			default: ;
		endcase
	endfunction

	function automatic logic [31:0] predict_drive(input logic kind, input logic [31:0] sp_b,
			input logic [31:0] ms_b, input logic [31:0] spv_b, input logic [31:0] mv_b);
		wide_t sp, jump, err, p, i, d, diff, rate, total;
		sp = sx(sp_b);
		if (kind == KIND_ERROR) begin
			jump = sp - last_sp_q;
			if (jump < 0) jump = -jump;
			if (jump > thresh_q) integral_q = 0;
		end
		err = clip(sp - sx(ms_b), DW);
		p = clip(q_mul(kp_q, err), AW);
		if (kind == KIND_ERROR) begin
			diff = clip(err - last_err_q, DW);
			rate = clip(q_mul(diff, rdt_q), AW);
			d = clip(q_mul(kd_q, rate), AW);
		end else begin
			diff = clip(sx(spv_b) - sx(mv_b), DW);
			d = clip(q_mul(kd_q, diff), AW);
		end
		integral_q = clip(integral_q + q_mul(err, dt_q), AW);
		i = clip(q_mul(ki_q, integral_q), AW);
		total = clip(p + i + d, AW);
		if (total > upper_q) total = upper_q;
		else if (total < lower_q) total = lower_q;
		last_err_q = err;
		if (kind == KIND_ERROR) last_sp_q = sp;
		return total[31:0];
	endfunction

	function automatic logic [31:0] rand_q();
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 4))
					0: return Q_MAX;
					1: return Q_MIN;
					2: return 32'h0;
					3: return 32'hFFFF_FFFF;
					default: return 32'h1;
				endcase
			end
			1, 2: return $urandom;
			default: return 32'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
		endcase
	endfunction

	function automatic logic [31:0] rand_gain();
		case ($urandom_range(0, 5))
			0: return ($urandom_range(0, 1) != 0) ? Q_MAX : Q_MIN;
			1: return $urandom;
			2: return 32'h0;
			default: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
		endcase
	endfunction

	function automatic logic [31:0] rand_period();
		case ($urandom_range(0, 5))
			0: return 32'h0;
			1: return Q_MAX;
			2: return {1'b0, 31'($urandom)};
			default: return 32'($urandom_range(0, 32'h0002_0000));
		endcase
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		note_reg(idx, v);
	endtask

	task automatic program_regs(input logic [31:0] kp, input logic [31:0] ki,
			input logic [31:0] kd, input logic [31:0] dt, input logic [31:0] rdt,
			input logic [31:0] up, input logic [31:0] lo, input logic [31:0] th);
		write_reg(REG_KP, kp);
		write_reg(REG_KI, ki);
		write_reg(REG_KD, kd);
		write_reg(REG_DT, dt);
		write_reg(REG_RDT, rdt);
		write_reg(REG_UPPER, up);
		write_reg(REG_LOWER, lo);
		write_reg(REG_THRESH, th);
		cfg_wen <= 1'b0;
	endtask

	task automatic send_tick(input logic kind, input logic [31:0] sp, input logic [31:0] ms,
			input logic [31:0] spv, input logic [31:0] mv);
		int gap;
		gap = (calm || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 10);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {mv, spv, ms, sp};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		drive_expect.push_back(predict_drive(kind, sp, ms, spv, mv));
		recent_sp = sp;
	endtask

	// sender holds off until every drive is back
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (drive_expect.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_random_tick();
		logic [31:0] sp;
		int          span;
		if ($urandom_range(0, 1) != 0) begin
			span = $urandom_range(0, 32'h0002_0000);
			sp = recent_sp + 32'($urandom_range(0, 2 * span)) - 32'(span);
		end else begin
			sp = rand_q();
		end
		send_tick($urandom_range(0, 1) != 0 ? KIND_VELOCITY : KIND_ERROR, sp, rand_q(),
			rand_q(), rand_q());
	endtask

	task automatic program_random();
		logic signed [31:0] a, b;
		logic [31:0]        up, lo, th;
		case ($urandom_range(0, 3))
			0: begin
				up = Q_MAX;
				lo = Q_MIN;
			end
			1: begin
				up = rand_q();
				lo = rand_q();
			end
			default: begin
				a = rand_q();
				b = rand_q();
				up = (a > b) ? a : b;
				lo = (a > b) ? b : a;
			end
		endcase
		case ($urandom_range(0, 3))
			0: th = 32'h0;
			1: th = Q_MAX;
			default: th = 32'($urandom_range(0, 32'h0002_0000));
		endcase
		program_regs(rand_gain(), rand_gain(), rand_gain(), rand_period(), rand_period(),
			up, lo, th);
	endtask

	task automatic test_reset_values();
		send_tick(KIND_ERROR, Q_ONE, 32'h0, 32'h0, 32'h0);
		send_tick(KIND_VELOCITY, 32'h0, Q_ONE, Q_MAX, Q_MIN);
		send_tick(KIND_ERROR, 32'h0, 32'h0, 32'h0, 32'h0);
	endtask

	task automatic test_error_mode();
		wait_idle();
		program_regs(Q_ONE, 32'h0000_8000, 32'h0000_4000, Q_ONE, 32'h0002_0000,
			Q_MAX, Q_MIN, 32'h0000_8000);
		// jump equal to threshold keeps the integral, one above clears it
		send_tick(KIND_ERROR, 32'h0000_8000, 32'h0, 32'h0, 32'h0);
		send_tick(KIND_ERROR, 32'h0001_0001, 32'h0, 32'h0, 32'h0);
		send_tick(KIND_ERROR, Q_MAX, Q_MIN, 32'h0, 32'h0);
		send_tick(KIND_ERROR, Q_MIN, Q_MAX, 32'h0, 32'h0);
		send_tick(KIND_ERROR, Q_MIN, 32'h0, Q_MAX, Q_MIN);
		send_tick(KIND_ERROR, 32'hFFFF_FFFF, 32'h1, 32'h0, 32'h0);
		send_tick(KIND_ERROR, 32'h0, 32'h0, 32'h0, 32'h0);
		send_tick(KIND_ERROR, Q_ONE, 32'hFFFF_0000, 32'h0, 32'h0);
	endtask

	task automatic test_velocity_mode();
		send_tick(KIND_VELOCITY, Q_ONE, 32'h0, Q_MAX, Q_MIN);
		send_tick(KIND_VELOCITY, Q_MAX, 32'h0, Q_MIN, Q_MAX);
		send_tick(KIND_VELOCITY, 32'h0, Q_MIN, 32'hFFFF_FFFF, 32'h1);
		// last setpoint untouched by velocity ticks
		send_tick(KIND_ERROR, Q_ONE, 32'h0, 32'h0, 32'h0);
		send_tick(KIND_ERROR, 32'h0001_4000, 32'h0, 32'h0, 32'h0);
	endtask

	task automatic test_output_clamp();
		wait_idle();
		program_regs(Q_ONE, 32'h0, 32'h0, Q_ONE, Q_ONE, 32'hFFFF_0000, Q_ONE, 32'h0000_8000);
		send_tick(KIND_ERROR, 32'h0003_0000, 32'h0, 32'h0, 32'h0);
		send_tick(KIND_ERROR, 32'h0, 32'h0003_0000, 32'h0, 32'h0);
		wait_idle();
		program_regs(Q_ONE, 32'h0, 32'h0, Q_ONE, Q_ONE, Q_ONE, 32'hFFFF_0000, 32'h0000_8000);
		send_tick(KIND_ERROR, 32'h0003_0000, 32'h0, 32'h0, 32'h0);
		send_tick(KIND_ERROR, 32'h0, 32'h0003_0000, 32'h0, 32'h0);
	endtask

	task automatic test_saturation();
		wait_idle();
		program_regs(Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MAX);
		send_tick(KIND_ERROR, Q_MAX, Q_MIN, 32'h0, 32'h0);
		send_tick(KIND_ERROR, Q_MAX, Q_MIN, 32'h0, 32'h0);
		send_tick(KIND_VELOCITY, Q_MAX, Q_MIN, Q_MIN, Q_MAX);
		wait_idle();
		program_regs(Q_MIN, Q_MAX, Q_MIN, 32'h0, 32'h0, Q_MAX, Q_MIN, 32'h0);
		send_tick(KIND_ERROR, Q_MIN, Q_MAX, 32'h0, 32'h0);
		send_tick(KIND_ERROR, Q_MIN, Q_MAX, 32'h0, 32'h0);
	endtask

	task automatic test_random_settings();
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			wait_idle();
			program_random();
			repeat (PHASE_TICKS) send_random_tick();
		end
	endtask

	task automatic test_quiet_tail();
		wait_idle();
		program_random();
		calm = 1'b1;
		repeat (TAIL_TICKS) send_random_tick();
	endtask

	// result check, receiver stalls and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (drive_expect.size() == 0) begin
					errors++;
					$display("%0t drive with no request: expected none, actual %h",
						$time, m_axis_tdata);
				end else begin
					drive_want = drive_expect.pop_front();
					if (m_axis_tdata !== drive_want) begin
						errors++;
						$display("%0t drive: expected %h, actual %h",
							$time, drive_want, m_axis_tdata);
					end
				end
			end
			if (calm) begin
				m_axis_tready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				m_axis_tready <= 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				stall_left <= $urandom_range(0, 9);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				quiet <= 0;
			end else if (quiet >= WATCHDOG_LIMIT) begin
				$display("pid_controller_two_mode_unit: mismatch");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_error_mode();
		test_velocity_mode();
		test_output_clamp();
		test_saturation();
		test_random_settings();
		test_quiet_tail();
		wait_idle();
		repeat (100) @(posedge clk);
		if (errors == 0 && drive_expect.size() == 0) begin
			$display("pid_controller_two_mode_unit: match");
		end else begin
			$display("pid_controller_two_mode_unit: mismatch");
		end
		$finish;
	end

endmodule
